[hdl/sweep_prune_pair_finder_unit_assert.svh]
`ifndef SWEEP_PRUNE_PAIR_FINDER_UNIT_ASSERT_SVH
`define SWEEP_PRUNE_PAIR_FINDER_UNIT_ASSERT_SVH
// clocked implication check with async reset disable
`define SPPF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication check
`define SPPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hdl/sppf_pkg.sv]
package sppf_pkg;
	localparam int unsigned LAYERS_DEF = 4;
	localparam int unsigned LIST_CAPACITY_DEF = 8;
	localparam int unsigned COORD_BITS_DEF = 20;
	localparam int unsigned MATRIX_BITS = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_PAIR    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STORE,
		ST_SUMMARY
	} state_t;
endpackage

[hdl/sppf_front.sv]
// Accepts requests, checks the layer, looks up the collision row and
// queues them for the back end.
module sppf_front #(
	parameter int unsigned LAYERS = sppf_pkg::LAYERS_DEF,
	parameter int unsigned COORD_BITS = sppf_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [sppf_pkg::MATRIX_BITS-1:0] layer_pairs,
	input  logic push,
	output logic full,
	input  logic cmd,
	input  logic [15:0] owner,
	input  logic [7:0] shape_index,
	input  logic [1:0] layer,
	input  logic non_moving,
	input  logic signed [COORD_BITS-1:0] min_x,
	input  logic signed [COORD_BITS-1:0] min_y,
	input  logic signed [COORD_BITS-1:0] max_x,
	input  logic signed [COORD_BITS-1:0] max_y,
	output logic q_valid,
	input  logic q_pop,
	output logic q_clear,
	output logic q_bad_layer,
	output logic [LAYERS-1:0] q_mask,
	output logic [15:0] q_owner,
	output logic [7:0] q_shape,
	output logic [$clog2(LAYERS > 1 ? LAYERS : 2)-1:0] q_layer,
	output logic q_fixed,
	output logic signed [COORD_BITS-1:0] q_lo_x,
	output logic signed [COORD_BITS-1:0] q_lo_y,
	output logic signed [COORD_BITS-1:0] q_hi_x,
	output logic signed [COORD_BITS-1:0] q_hi_y
);
	import sppf_pkg::*;
	localparam int unsigned LW = $clog2(LAYERS > 1 ? LAYERS : 2);

	typedef struct packed {
		logic clear;
		logic bad_layer;
		logic [LAYERS-1:0] mask;
		logic [15:0] owner;
		logic [7:0] shape;
		logic [LW-1:0] layer;
		logic fixed;
		logic signed [COORD_BITS-1:0] lo_x;
		logic signed [COORD_BITS-1:0] lo_y;
		logic signed [COORD_BITS-1:0] hi_x;
		logic signed [COORD_BITS-1:0] hi_y;
	} entry_t;

	entry_t ent_q [QUEUE_DEPTH];
	entry_t new_ent;
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	always_comb begin
		new_ent = '0;
		new_ent.clear = (cmd == CMD_CLEAR);
		new_ent.bad_layer = ({30'd0, layer} >= 32'(LAYERS));
		new_ent.owner = owner;
		new_ent.shape = shape_index;
		new_ent.layer = LW'(layer);
		new_ent.fixed = non_moving;
		new_ent.lo_x = min_x;
		new_ent.lo_y = min_y;
		new_ent.hi_x = max_x;
		new_ent.hi_y = max_y;
		for (int b = 0; b < LAYERS; b++) begin
			if (32'(layer) * 32'(LAYERS) + 32'(b) < 32'(MATRIX_BITS))
				new_ent.mask[b] = layer_pairs[4'(32'(layer) * 32'(LAYERS) + 32'(b))];
		end
	end

	assign full = (cnt_q == 2'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop = q_pop && q_valid;
	assign q_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= new_ent;
	end

	assign q_clear = ent_q[rd_ptr_q].clear;
	assign q_bad_layer = ent_q[rd_ptr_q].bad_layer;
	assign q_mask = ent_q[rd_ptr_q].mask;
	assign q_owner = ent_q[rd_ptr_q].owner;
	assign q_shape = ent_q[rd_ptr_q].shape;
	assign q_layer = ent_q[rd_ptr_q].layer;
	assign q_fixed = ent_q[rd_ptr_q].fixed;
	assign q_lo_x = ent_q[rd_ptr_q].lo_x;
	assign q_lo_y = ent_q[rd_ptr_q].lo_y;
	assign q_hi_x = ent_q[rd_ptr_q].hi_x;
	assign q_hi_y = ent_q[rd_ptr_q].hi_y;
endmodule

[hdl/sppf_back.sv]
// Scans the active lists one entry per cycle while the result queue has
// room, compacts them in place and emits pairs into a two-entry result queue.
module sppf_back #(
	parameter int unsigned LAYERS = sppf_pkg::LAYERS_DEF,
	parameter int unsigned LIST_CAPACITY = sppf_pkg::LIST_CAPACITY_DEF,
	parameter int unsigned COORD_BITS = sppf_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  logic q_clear,
	input  logic q_bad_layer,
	input  logic [LAYERS-1:0] q_mask,
	input  logic [15:0] q_owner,
	input  logic [7:0] q_shape,
	input  logic [$clog2(LAYERS > 1 ? LAYERS : 2)-1:0] q_layer,
	input  logic q_fixed,
	input  logic signed [COORD_BITS-1:0] q_lo_x,
	input  logic signed [COORD_BITS-1:0] q_lo_y,
	input  logic signed [COORD_BITS-1:0] q_hi_x,
	input  logic signed [COORD_BITS-1:0] q_hi_y,
	output logic empty,
	input  logic pop,
	output logic kind,
	output logic [15:0] new_owner,
	output logic [7:0] new_shape,
	output logic [15:0] old_owner,
	output logic [7:0] old_shape,
	output logic overflow,
	output logic last,
	output logic busy
);
	import sppf_pkg::*;
	localparam int unsigned LW = $clog2(LAYERS > 1 ? LAYERS : 2);
	localparam int unsigned IW = $clog2(LIST_CAPACITY);
	localparam int unsigned CW = $clog2(LIST_CAPACITY + 1);
	localparam int unsigned AW = LW + IW;
	localparam int unsigned DEPTH = LAYERS * (2 ** IW);

	typedef struct packed {
		logic [15:0] owner;
		logic [7:0] shape;
		logic fixed;
		logic signed [COORD_BITS-1:0] lo_x;
		logic signed [COORD_BITS-1:0] hi_x;
		logic signed [COORD_BITS-1:0] lo_y;
		logic signed [COORD_BITS-1:0] hi_y;
	} slot_t;

	typedef struct packed {
		logic kind;
		logic [15:0] no;
		logic [7:0] ns;
		logic [15:0] oo;
		logic [7:0] os;
		logic ov;
		logic last;
	} res_t;

	slot_t mem [DEPTH];
	slot_t rd_s1;
	logic [CW-1:0] count_q [LAYERS];

	state_t state_q, state_d;
	logic [LW-1:0] lay_q;
	logic [CW-1:0] rd_idx_q, kept_q;
	logic rd_pend_s1;
	logic scan_done;

	res_t rq_q [2];
	logic rq_wr_q, rq_rd_q;
	logic [1:0] rq_cnt_q;
	logic rq_room, rq_push;
	res_t rq_in;

	logic issue, e_keep, e_pair, mem_we, ov_flag;
	logic ov_flag_q;
	logic [AW-1:0] mem_wa, mem_ra;
	slot_t mem_wd;

	function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [IW-1:0] i);
		addr = {l, i};
	endfunction

	// room for one more result, counting a possible one still in the read stage
	assign rq_room = (rq_cnt_q == 2'd0) || (rq_cnt_q == 2'd1 && !rd_pend_s1);

	assign scan_done = !q_mask[lay_q] || (rd_idx_q >= count_q[lay_q]);
	assign issue = (state_q == ST_SCAN) && !scan_done && rq_room;
	assign mem_ra = addr(lay_q, rd_idx_q[IW-1:0]);

	assign e_keep = rd_pend_s1 && !(q_lo_x > rd_s1.hi_x);
	assign e_pair = e_keep && (rd_s1.owner != q_owner) && (rd_s1.lo_x <= q_hi_x)
		&& (q_lo_y <= rd_s1.hi_y) && (rd_s1.lo_y <= q_hi_y) && !(q_fixed && rd_s1.fixed);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_clear || q_bad_layer) state_d = ST_SUMMARY;
					else state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done && !rd_pend_s1 && {1'b0, lay_q} == (LW+1)'(LAYERS - 1))
					state_d = ST_STORE;
			end
			ST_STORE: state_d = ST_SUMMARY;
			ST_SUMMARY: begin
				if (rq_cnt_q != 2'd2) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr(lay_q, kept_q[IW-1:0]);
		mem_wd = rd_s1;
		rq_push = 1'b0;
		rq_in = '0;
		q_pop = 1'b0;
		ov_flag = q_bad_layer || (count_q[q_layer] >= CW'(LIST_CAPACITY));
		unique case (state_q)
			ST_SCAN: begin
				mem_we = e_keep;
				rq_push = e_pair;
				rq_in.kind = KIND_PAIR;
				rq_in.no = q_owner;
				rq_in.ns = q_shape;
				rq_in.oo = rd_s1.owner;
				rq_in.os = rd_s1.shape;
			end
			ST_STORE: begin
				mem_we = !ov_flag;
				mem_wa = addr(q_layer, count_q[q_layer][IW-1:0]);
				mem_wd.owner = q_owner;
				mem_wd.shape = q_shape;
				mem_wd.fixed = q_fixed;
				mem_wd.lo_x = q_lo_x;
				mem_wd.hi_x = q_hi_x;
				mem_wd.lo_y = q_lo_y;
				mem_wd.hi_y = q_hi_y;
			end
			ST_SUMMARY: begin
				rq_push = (rq_cnt_q != 2'd2);
				q_pop = rq_push;
				rq_in.kind = KIND_SUMMARY;
				rq_in.last = 1'b1;
				if (!q_clear) begin
					rq_in.no = q_owner;
					rq_in.ns = q_shape;
					rq_in.ov = q_bad_layer || ov_flag_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lay_q <= '0;
			rd_idx_q <= '0;
			kept_q <= '0;
			rd_pend_s1 <= 1'b0;
			ov_flag_q <= 1'b0;
			for (int l = 0; l < LAYERS; l++) count_q[l] <= '0;
			rq_wr_q <= 1'b0;
			rq_rd_q <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			rd_pend_s1 <= issue;
			if (issue) rd_idx_q <= rd_idx_q + 1'b1;
			if (state_q == ST_SCAN && e_keep) kept_q <= kept_q + 1'b1;
			if (state_q == ST_IDLE) begin
				lay_q <= '0;
				rd_idx_q <= '0;
				kept_q <= '0;
				if (q_valid && q_clear)
					for (int l = 0; l < LAYERS; l++) count_q[l] <= '0;
			end else if (state_q == ST_SCAN && scan_done && !rd_pend_s1) begin
				// layer finished: commit compacted length, move on
				if (q_mask[lay_q]) count_q[lay_q] <= kept_q;
				if ({1'b0, lay_q} != (LW+1)'(LAYERS - 1)) lay_q <= lay_q + 1'b1;
				rd_idx_q <= '0;
				kept_q <= '0;
			end
			if (state_q == ST_STORE) begin
				ov_flag_q <= ov_flag;
				if (!ov_flag) count_q[q_layer] <= count_q[q_layer] + 1'b1;
			end
			if (state_q == ST_IDLE) ov_flag_q <= 1'b0;
			if (rq_push) rq_wr_q <= !rq_wr_q;
			if (pop && !empty) rq_rd_q <= !rq_rd_q;
			rq_cnt_q <= rq_cnt_q + 2'(rq_push) - 2'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (issue) rd_s1 <= mem[mem_ra];
		if (rq_push) rq_q[rq_wr_q] <= rq_in;
	end

	assign empty = (rq_cnt_q == 2'd0);
	assign kind = rq_q[rq_rd_q].kind;
	assign new_owner = rq_q[rq_rd_q].no;
	assign new_shape = rq_q[rq_rd_q].ns;
	assign old_owner = rq_q[rq_rd_q].oo;
	assign old_shape = rq_q[rq_rd_q].os;
	assign overflow = rq_q[rq_rd_q].ov;
	assign last = rq_q[rq_rd_q].last;
	assign busy = (state_q != ST_IDLE);
endmodule

[hdl/sweep_prune_pair_finder_unit.sv]
// Sweep-and-prune broad phase. Boxes must be sent sorted by min_x; the
// block does not enforce it. Each insert scans the active list of every
// layer the collision matrix allows, one entry per cycle while the result
// queue has room, through a list memory with a read and a write port,
// compacting away entries that ended left of the new box and queuing one
// pair per hit, then stores the box and ends with a summary result
// (last=1). An insert goes from idle through the scan of each layer (a
// masked-off layer or empty list is skipped without reads) and a store
// state to the summary, which waits on a full result queue; a clear goes
// from idle straight to the summary. A two-entry request queue in front
// and a two-entry result queue behind decouple the ports.
module sweep_prune_pair_finder_unit #(
	parameter int unsigned LAYERS = sppf_pkg::LAYERS_DEF,
	parameter int unsigned LIST_CAPACITY = sppf_pkg::LIST_CAPACITY_DEF,
	parameter int unsigned COORD_BITS = sppf_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [sppf_pkg::MATRIX_BITS-1:0] cfg_data,
	input  logic push,
	output logic full,
	input  logic cmd,
	input  logic [15:0] owner,
	input  logic [7:0] shape_index,
	input  logic [1:0] layer,
	input  logic non_moving,
	input  logic signed [COORD_BITS-1:0] min_x,
	input  logic signed [COORD_BITS-1:0] min_y,
	input  logic signed [COORD_BITS-1:0] max_x,
	input  logic signed [COORD_BITS-1:0] max_y,
	output logic empty,
	input  logic pop,
	output logic kind,
	output logic [15:0] new_owner,
	output logic [7:0] new_shape,
	output logic [15:0] old_owner,
	output logic [7:0] old_shape,
	output logic overflow,
	output logic last
);
	import sppf_pkg::*;
	`include "sweep_prune_pair_finder_unit_assert.svh"
	localparam int unsigned LW = $clog2(LAYERS > 1 ? LAYERS : 2);

	logic [MATRIX_BITS-1:0] layer_pairs_q;
	logic q_valid, q_pop, q_clear, q_bad_layer, q_fixed, busy;
	logic [LAYERS-1:0] q_mask;
	logic [15:0] q_owner;
	logic [7:0] q_shape;
	logic [LW-1:0] q_layer;
	logic signed [COORD_BITS-1:0] q_lo_x, q_lo_y, q_hi_x, q_hi_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) layer_pairs_q <= '1;
		else if (cfg_valid && cfg_ready) layer_pairs_q <= cfg_data;
	end

	sppf_front #(.LAYERS(LAYERS), .COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .layer_pairs(layer_pairs_q), .push, .full, .cmd, .owner,
		.shape_index, .layer, .non_moving, .min_x, .min_y, .max_x, .max_y,
		.q_valid, .q_pop, .q_clear, .q_bad_layer, .q_mask, .q_owner, .q_shape,
		.q_layer, .q_fixed, .q_lo_x, .q_lo_y, .q_hi_x, .q_hi_y
	);

	sppf_back #(.LAYERS(LAYERS), .LIST_CAPACITY(LIST_CAPACITY),
		.COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_clear, .q_bad_layer, .q_mask,
		.q_owner, .q_shape, .q_layer, .q_fixed, .q_lo_x, .q_lo_y, .q_hi_x,
		.q_hi_y, .empty, .pop, .kind, .new_owner, .new_shape, .old_owner,
		.old_shape, .overflow, .last, .busy
	);

	`SPPF_ASSERT_IMPL(a_pair_not_last, !empty && kind == KIND_PAIR, !last && !overflow, "pair flagged last")
	`SPPF_ASSERT_IMPL(a_summary_last, !empty && kind == KIND_SUMMARY, last && old_owner == 16'd0, "bad summary")
	`SPPF_ASSERT_NEXT(a_pop_ends_item, q_pop, !busy, "request not retired")
endmodule

[verif/tb_top.sv]
module tb_top;
	import sppf_pkg::*;

	localparam int NLAYERS = LAYERS_DEF;
	localparam int CAP = LIST_CAPACITY_DEF;
	localparam int CW = COORD_BITS_DEF;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		kind_t kind;
		logic [15:0] new_owner;
		logic [7:0] new_shape;
		logic [15:0] old_owner;
		logic [7:0] old_shape;
		logic overflow;
		logic last;
	} pair_rec_t;

	typedef struct {
		cmd_t cmd;
		logic [15:0] owner;
		logic [7:0] shape;
		logic [1:0] layer;
		logic fixed;
		logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y;
	} box_req_t;

	class pair_scoreboard;
		logic [15:0] matrix;
		box_req_t lists[NLAYERS][CAP];
		int count[NLAYERS];
		pair_rec_t pending[$];
		int mismatches;

		function void reset_state();
			matrix = 16'hFFFF;
			foreach (count[i]) count[i] = 0;
			pending.delete();
			mismatches = 0;
		endfunction

		function void note_request(box_req_t b);
			pair_rec_t r;
			int kept;
			box_req_t e;
			if (b.cmd == CMD_CLEAR) begin
				foreach (count[i]) count[i] = 0;
				r = '0;
				r.kind = KIND_SUMMARY;
				r.last = 1'b1;
				pending.insert(pending.size(), r);
				return;
			end
			for (int l = 0; l < NLAYERS; l++) begin
				if (b.layer * NLAYERS + l >= MATRIX_BITS || !matrix[b.layer * NLAYERS + l])
					continue;
				kept = 0;
				for (int j = 0; j < count[l]; j++) begin
					e = lists[l][j];
					if (b.lo_x > e.hi_x) continue;
					lists[l][kept++] = e;
					if (e.owner != b.owner && e.lo_x <= b.hi_x && b.lo_y <= e.hi_y
					    && e.lo_y <= b.hi_y && !(b.fixed && e.fixed)) begin
						r = '0;
						r.kind = KIND_PAIR;
						r.new_owner = b.owner;
						r.new_shape = b.shape;
						r.old_owner = e.owner;
						r.old_shape = e.shape;
						pending.insert(pending.size(), r);
					end
				end
				count[l] = kept;
			end
			r = '0;
			r.kind = KIND_SUMMARY;
			r.new_owner = b.owner;
			r.new_shape = b.shape;
			r.last = 1'b1;
			if (count[b.layer] < CAP) begin
				lists[b.layer][count[b.layer]] = b;
				count[b.layer]++;
			end else begin
				r.overflow = 1'b1;
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(pair_rec_t got);
			pair_rec_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [15:0] cfg_data = '0;
	logic push = 0, full, empty, pop = 0;
	logic cmd = 0, non_moving = 0;
	logic [15:0] owner = '0;
	logic [7:0] shape_index = '0;
	logic [1:0] layer = '0;
	logic signed [CW-1:0] min_x = '0, min_y = '0, max_x = '0, max_y = '0;
	logic kind, overflow, last;
	logic [15:0] new_owner, old_owner;
	logic [7:0] new_shape, old_shape;

	sweep_prune_pair_finder_unit u_top (.*);

	pair_scoreboard sb;
	longint cycles = 0;
	int hold_cycles = 0;
	int sweep_x;

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// result side: random pops; a forced hold-off counted here
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result('{kind_t'(kind), new_owner, new_shape, old_owner, old_shape,
			                  overflow, last});
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 3) != 0);
		end
	end

	// push stays high between back-to-back requests and drops here and in drain
	task automatic idle(int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send(box_req_t b);
		push <= 1'b1;
		cmd <= b.cmd;
		owner <= b.owner;
		shape_index <= b.shape;
		layer <= b.layer;
		non_moving <= b.fixed;
		min_x <= b.lo_x;
		min_y <= b.lo_y;
		max_x <= b.hi_x;
		max_y <= b.hi_y;
		do @(posedge clk); while (full);
		sb.note_request(b);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_matrix(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.matrix = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic box_req_t rand_box(bit wide_coords);
		box_req_t b;
		int w;
		b.cmd = CMD_INSERT;
		b.owner = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
		b.shape = 8'($urandom);
		b.layer = 2'($urandom);
		b.fixed = ($urandom_range(0, 3) == 0);
		if (wide_coords) begin
			b.lo_x = CW'($urandom);
			b.hi_x = CW'($urandom);
			b.lo_y = CW'($urandom);
			b.hi_y = CW'($urandom);
		end else begin
			// ascending sweep with overlapping boxes
			sweep_x += $urandom_range(0, 40);
			w = $urandom_range(0, 120);
			b.lo_x = CW'(sweep_x);
			b.hi_x = CW'(sweep_x + w);
			b.lo_y = CW'($signed($urandom_range(0, 400)) - 200);
			b.hi_y = b.lo_y + CW'($urandom_range(0, 200));
		end
		return b;
	endfunction

	function automatic box_req_t clear_req();
		box_req_t b = rand_box(1);
		b.cmd = CMD_CLEAR;
		return b;
	endfunction

	initial begin
		box_req_t b;
		logic [15:0] settings[4];
		settings = '{16'h0000, 16'hA5C3, 16'h8421, 16'hFFFF};
		sb = new();
		sb.reset_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, fixed pairs, same owner, overflow, clear
		sweep_x = -300;
		b = rand_box(0);
		b.lo_x = {1'b1, {(CW-1){1'b0}}}; b.lo_y = b.lo_x;
		b.hi_x = {1'b0, {(CW-1){1'b1}}}; b.hi_y = b.hi_x;
		b.owner = 16'hFFFF; b.shape = 8'hFF; b.layer = 2'd3; b.fixed = 1'b1;
		send(b);
		b.owner = 16'h0000; b.shape = 8'h00; send(b);
		b.fixed = 1'b0; send(b);
		b.owner = 16'hFFFF; send(b);
		b.lo_x = CW'(20); b.hi_x = CW'(-20); b.layer = 2'd0; send(b);
		for (int i = 0; i < 10; i++) begin
			b = rand_box(0);
			b.layer = 2'd1;
			b.lo_x = CW'(0); b.hi_x = CW'(1000); b.lo_y = CW'(0); b.hi_y = CW'(10);
			b.owner = 16'(i);
			send(b);
		end
		send(clear_req());
		b = rand_box(0); send(b);
		drain();

		// random phases across matrix settings; first phase stalls the receiver
		for (int p = 0; p < 5; p++) begin
			if (p < 4) write_matrix(settings[p] ^ ((p == 1) ? 16'($urandom) : 16'h0));
			else write_matrix(16'($urandom));
			sweep_x = -int'($urandom_range(0, 2000));
			if (p == 0) hold_cycles = 400;
			for (int i = 0; i < 48; i++) begin
				if ($urandom_range(0, 24) == 0) begin
					send(clear_req());
					sweep_x = -int'($urandom_range(0, 2000));
				end else begin
					send(rand_box($urandom_range(0, 9) == 0));
				end
				if (hold_cycles == 0) idle(pick_gap());
			end
			drain();
		end
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+hdl
hdl/sppf_pkg.sv
hdl/sppf_front.sv
hdl/sppf_back.sv
hdl/sweep_prune_pair_finder_unit.sv
verif/tb_top.sv
